>>> sv/gclp_pkg.sv
// ----------------------------------------------------------------------------
// gclp_pkg: shared types and constants of the G-code line parser
// Character codes, result kinds, the result item type and the small lookup
// tables for parameter letters and powers of ten.
// ----------------------------------------------------------------------------
package gclp_pkg;

    localparam int MANT_W      = 64;
    localparam int DIVISOR_W   = 24;
    localparam int NUM_SLOTS   = 11;
    localparam int SLOT_W      = 4;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;

    localparam logic [SLOT_W-1:0] CMD_SLOT = 4'd11;

    // Saturation value, and the largest accumulator value that can still take one more digit
    localparam logic [MANT_W-1:0] MANT_SAT = 64'h8000_0000_0000_0000;
    localparam logic [MANT_W-1:0] MANT_LIM = (MANT_SAT - 64'd9) / 64'd10;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_LOW_A = 8'h61;
    localparam logic [7:0] CH_LOW_Z = 8'h7A;
    localparam logic [7:0] CASE_OFS = 8'h20;

    localparam logic [1:0] KIND_HDR  = 2'd0;
    localparam logic [1:0] KIND_WORD = 2'd1;
    localparam logic [1:0] KIND_ACK  = 2'd2;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  letter;
        logic [15:0] cnum;
        logic [31:0] value;
        logic        last;
    } res_t;

    typedef struct packed {
        logic              hit;
        logic [SLOT_W-1:0] idx;
    } slot_hit_t;

    function automatic logic [DIVISOR_W-1:0] pow10(input logic [2:0] n);
        logic [DIVISOR_W-1:0] p;
        case (n)
            3'd0: p = 24'd1;
            3'd1: p = 24'd10;
            3'd2: p = 24'd100;
            3'd3: p = 24'd1000;
            3'd4: p = 24'd10000;
            3'd5: p = 24'd100000;
            3'd6: p = 24'd1000000;
            3'd7: p = 24'd10000000;
            default: p = 24'd1;
        endcase
        return p;
    endfunction

    function automatic logic [7:0] slot_letter(input logic [SLOT_W-1:0] idx);
        logic [7:0] c;
        case (idx)
            4'd0:  c = "X";
            4'd1:  c = "Y";
            4'd2:  c = "Z";
            4'd3:  c = "E";
            4'd4:  c = "A";
            4'd5:  c = "B";
            4'd6:  c = "C";
            4'd7:  c = "F";
            4'd8:  c = "S";
            4'd9:  c = "P";
            4'd10: c = "T";
            default: c = 8'd0;
        endcase
        return c;
    endfunction

    function automatic slot_hit_t slot_lookup(input logic [7:0] c);
        slot_hit_t r;
        r.hit = 1'b1;
        case (c)
            "X": r.idx = 4'd0;
            "Y": r.idx = 4'd1;
            "Z": r.idx = 4'd2;
            "E": r.idx = 4'd3;
            "A": r.idx = 4'd4;
            "B": r.idx = 4'd5;
            "C": r.idx = 4'd6;
            "F": r.idx = 4'd7;
            "S": r.idx = 4'd8;
            "P": r.idx = 4'd9;
            "T": r.idx = 4'd10;
            default: begin
                r.hit = 1'b0;
                r.idx = 4'd0;
            end
        endcase
        return r;
    endfunction

    function automatic logic [7:0] upcase(input logic [7:0] c);
        logic [7:0] u;
        u = c;
        if (c >= CH_LOW_A && c <= CH_LOW_Z) begin
            u = c - CASE_OFS;
        end
        return u;
    endfunction

endpackage

>>> sv/gclp_div.sv
// ----------------------------------------------------------------------------
// gclp_div: radix-2 restoring divider for number conversion
// Divides the decimal accumulator by a power of ten one quotient bit per
// cycle, continuing into FRAC_BITS fraction bits for parameter values.
// ----------------------------------------------------------------------------
module gclp_div #(
    parameter int FRAC_BITS   = 16,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            start,
    input  logic                            is_cmd,
    input  logic [gclp_pkg::MANT_W-1:0]     dividend,
    input  logic [gclp_pkg::DIVISOR_W-1:0]  divisor,
    output logic                            done,
    output logic [VALUE_WIDTH-1:0]          quot,
    output logic                            ovf,
    output logic                            round_up
);

    localparam int DVD_W = gclp_pkg::MANT_W;
    localparam int DS_W  = gclp_pkg::DIVISOR_W;
    localparam int CNT_W = $clog2(DVD_W + FRAC_BITS + 1);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [DVD_W-1:0]  dvd_reg, dvd_next;
    logic [DS_W-1:0]   dvs_reg, dvs_next;
    logic [DS_W-1:0]   rem_reg, rem_next;
    logic [VALUE_WIDTH-1:0] quot_reg, quot_next;
    logic              ovf_reg, ovf_next;
    logic              cmd_reg, cmd_next;

    logic [DS_W:0]     rem2;
    logic [DS_W:0]     rem_sub;
    logic              ge;
    logic [VALUE_WIDTH-1:0] q_shift;

    always_comb begin
        rem2    = {rem_reg, dvd_reg[DVD_W-1]};
        ge      = rem2 >= {1'b0, dvs_reg};
        rem_sub = rem2 - {1'b0, dvs_reg};
        q_shift = {quot_reg[VALUE_WIDTH-2:0], ge};

        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        dvs_next  = dvs_reg;
        rem_next  = rem_reg;
        quot_next = quot_reg;
        ovf_next  = ovf_reg;
        cmd_next  = cmd_reg;

        if (start) begin
            busy_next = 1'b1;
            cnt_next  = is_cmd ? CNT_W'(DVD_W) : CNT_W'(DVD_W + FRAC_BITS);
            dvd_next  = dividend;
            dvs_next  = divisor;
            rem_next  = '0;
            quot_next = '0;
            ovf_next  = 1'b0;
            cmd_next  = is_cmd;
        end else if (busy_reg) begin
            dvd_next  = {dvd_reg[DVD_W-2:0], 1'b0};
            rem_next  = ge ? rem_sub[DS_W-1:0] : rem2[DS_W-1:0];
            quot_next = q_shift;
            // flag any quotient bit reaching the saturation position
            ovf_next  = ovf_reg | (cmd_reg ? q_shift[15] : q_shift[VALUE_WIDTH-1]);
            cnt_next  = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        dvd_reg  <= dvd_next;
        dvs_reg  <= dvs_next;
        rem_reg  <= rem_next;
        quot_reg <= quot_next;
        ovf_reg  <= ovf_next;
        cmd_reg  <= cmd_next;
    end

    assign done     = done_reg;
    assign quot     = quot_reg;
    assign ovf      = ovf_reg;
    assign round_up = {rem_reg, 1'b0} >= {1'b0, dvs_reg};

endmodule

>>> sv/gclp_front.sv
// ----------------------------------------------------------------------------
// gclp_front: byte classifier, number accumulator and command sequencer
// Parses one byte per accepted item, converts finished numbers with the
// divider and pushes the resulting items into the queue one per cycle while it has space.
// ----------------------------------------------------------------------------
module gclp_front #(
    parameter int FRAC_BITS       = 16,
    parameter int MAX_FRAC_DIGITS = 6,
    parameter int VALUE_WIDTH     = 32
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [7:0]           in_byte,
    output logic                 push_valid,
    input  logic                 push_ready,
    output gclp_pkg::res_t       push_item
);

    localparam int VW  = VALUE_WIDTH;
    localparam int VW1 = VALUE_WIDTH + 1;
    localparam int NS  = gclp_pkg::NUM_SLOTS;
    localparam int SW  = gclp_pkg::SLOT_W;
    localparam int MW  = gclp_pkg::MANT_W;

    typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_WORD, ST_EMIT} st_t;
    typedef enum logic [1:0] {PH_LETTER, PH_NUMBER, PH_WORD, PH_SKIP} ph_t;

    st_t              st_reg, st_next;
    ph_t              ph_reg, ph_next;
    logic [7:0]       cmd_letter_reg, cmd_letter_next;
    logic [15:0]      cmd_num_reg, cmd_num_next;
    logic [SW-1:0]    slot_reg, slot_next;
    logic [MW-1:0]    mant_reg, mant_next;
    logic [2:0]       fdig_reg, fdig_next;
    logic             neg_reg, neg_next;
    logic             infrac_reg, infrac_next;
    logic [NS-1:0]    present_reg, present_next;
    logic [7:0]       byte_reg, byte_next;
    logic             em_hdr_reg, em_hdr_next;
    logic [NS-1:0]    em_mask_reg, em_mask_next;
    logic             em_ack_reg, em_ack_next;
    logic [VW-1:0]    slot_val_reg [NS];
    logic             val_we;
    logic [VW-1:0]    val_wdata;

    logic             acc;
    logic             do_word;
    logic [7:0]       wb;
    logic [7:0]       wb_up;
    logic             wb_eol;
    gclp_pkg::slot_hit_t wb_hit;
    logic             in_eol;
    logic             in_digit;
    logic [3:0]       digit;

    logic             div_start;
    logic             div_done;
    logic [VW-1:0]    div_quot;
    logic             div_ovf;
    logic             div_round;

    logic [16:0]      magc, limc;
    logic [VW1-1:0]   magv, limv;
    logic [VW-1:0]    sval;

    logic [SW-1:0]    em_idx;
    logic [NS-1:0]    em_rest;
    logic [VW+31:0]   val_ext;

    gclp_div #(
        .FRAC_BITS   (FRAC_BITS),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .is_cmd   (slot_reg == gclp_pkg::CMD_SLOT),
        .dividend (mant_reg),
        .divisor  (gclp_pkg::pow10(fdig_reg)),
        .done     (div_done),
        .quot     (div_quot),
        .ovf      (div_ovf),
        .round_up (div_round)
    );

    assign in_ready = (st_reg == ST_IDLE);
    assign acc      = in_valid && in_ready;
    assign in_eol   = (in_byte == gclp_pkg::CH_CR) || (in_byte == gclp_pkg::CH_LF);
    assign in_digit = (in_byte >= gclp_pkg::CH_0) && (in_byte <= gclp_pkg::CH_9);
    assign digit    = 4'(in_byte - gclp_pkg::CH_0);

    assign wb      = (st_reg == ST_WORD) ? byte_reg : in_byte;
    assign wb_up   = gclp_pkg::upcase(wb);
    assign wb_eol  = (wb == gclp_pkg::CH_CR) || (wb == gclp_pkg::CH_LF);
    assign wb_hit  = gclp_pkg::slot_lookup(wb_up);
    assign do_word = (st_reg == ST_WORD) || (acc && ph_reg == PH_WORD);

    // Conversion of the finished number, rounded and saturated
    always_comb begin
        magc = {1'b0, div_quot[15:0]} + 17'(div_round);
        limc = neg_reg ? 17'd32768 : 17'd32767;
        if (div_ovf || magc > limc) begin
            magc = limc;
        end
        magv = {1'b0, div_quot} + VW1'(div_round);
        limv = neg_reg ? (VW1'(1) << (VW - 1)) : ((VW1'(1) << (VW - 1)) - VW1'(1));
        if (div_ovf || magv > limv) begin
            magv = limv;
        end
        sval = neg_reg ? (VW'(0) - magv[VW-1:0]) : magv[VW-1:0];
    end

    // Lowest pending parameter slot
    always_comb begin
        em_idx = '0;
        for (int i = NS - 1; i >= 0; i--) begin
            if (em_mask_reg[i]) begin
                em_idx = SW'(i);
            end
        end
        em_rest = em_mask_reg & ~(NS'(1) << em_idx);
        val_ext = {32'd0, slot_val_reg[em_idx]};
    end

    always_comb begin
        st_next         = st_reg;
        ph_next         = ph_reg;
        cmd_letter_next = cmd_letter_reg;
        cmd_num_next    = cmd_num_reg;
        slot_next       = slot_reg;
        mant_next       = mant_reg;
        fdig_next       = fdig_reg;
        neg_next        = neg_reg;
        infrac_next     = infrac_reg;
        present_next    = present_reg;
        byte_next       = byte_reg;
        em_hdr_next     = em_hdr_reg;
        em_mask_next    = em_mask_reg;
        em_ack_next     = em_ack_reg;
        div_start       = 1'b0;
        val_we          = 1'b0;
        val_wdata       = sval;
        push_valid      = 1'b0;
        push_item       = '0;

        if (acc) begin
            case (ph_reg)
                PH_LETTER: begin
                    if (in_eol) begin
                        em_ack_next = 1'b1;
                    end else if (in_byte != gclp_pkg::CH_SPACE) begin
                        cmd_letter_next = gclp_pkg::upcase(in_byte);
                        present_next    = '0;
                        slot_next       = gclp_pkg::CMD_SLOT;
                        mant_next       = '0;
                        fdig_next       = '0;
                        neg_next        = 1'b0;
                        infrac_next     = 1'b0;
                        ph_next         = PH_NUMBER;
                    end
                end
                PH_NUMBER: begin
                    if (in_byte == gclp_pkg::CH_DOT) begin
                        infrac_next = 1'b1;
                    end else if (in_byte == gclp_pkg::CH_MINUS) begin
                        neg_next = 1'b1;
                    end else if (in_digit) begin
                        if (!infrac_reg || fdig_reg < 3'(MAX_FRAC_DIGITS)) begin
                            if (mant_reg > gclp_pkg::MANT_LIM) begin
                                mant_next = gclp_pkg::MANT_SAT;
                            end else begin
                                mant_next = (mant_reg << 3) + (mant_reg << 1) + MW'(digit);
                            end
                            if (infrac_reg) begin
                                fdig_next = fdig_reg + 3'd1;
                            end
                        end
                    end else begin
                        // hold the byte until the number is converted
                        byte_next = in_byte;
                        div_start = 1'b1;
                    end
                end
                PH_WORD: begin
                end
                PH_SKIP: begin
                    if (in_eol) begin
                        em_ack_next = 1'b1;
                        ph_next     = PH_LETTER;
                    end
                end
                default: begin
                end
            endcase
        end

        if (st_reg == ST_DIV && div_done) begin
            if (slot_reg == gclp_pkg::CMD_SLOT) begin
                cmd_num_next = neg_reg ? (16'd0 - magc[15:0]) : magc[15:0];
            end else begin
                val_we       = 1'b1;
                present_next = present_reg | (NS'(1) << slot_reg);
            end
            ph_next = PH_WORD;
            st_next = ST_WORD;
        end

        if (do_word && wb != gclp_pkg::CH_SPACE) begin
            if (wb == gclp_pkg::CH_SEMI || wb_eol || !wb_hit.hit) begin
                em_hdr_next  = (cmd_letter_reg != gclp_pkg::CH_SEMI);
                em_mask_next = (cmd_letter_reg != gclp_pkg::CH_SEMI) ? present_reg : '0;
                em_ack_next  = wb_eol;
                present_next = '0;
                ph_next      = (wb == gclp_pkg::CH_SEMI || wb_eol) ? PH_LETTER : PH_SKIP;
            end else begin
                slot_next   = wb_hit.idx;
                mant_next   = '0;
                fdig_next   = '0;
                neg_next    = 1'b0;
                infrac_next = 1'b0;
                ph_next     = PH_NUMBER;
            end
        end

        if (acc || st_reg == ST_WORD) begin
            if (div_start) begin
                st_next = ST_DIV;
            end else if (em_hdr_next || em_mask_next != '0 || em_ack_next) begin
                st_next = ST_EMIT;
            end else begin
                st_next = ST_IDLE;
            end
        end

        if (st_reg == ST_EMIT) begin
            push_valid = 1'b1;
            if (em_hdr_reg) begin
                push_item.kind   = gclp_pkg::KIND_HDR;
                push_item.letter = cmd_letter_reg;
                push_item.cnum   = cmd_num_reg;
                push_item.last   = (em_mask_reg == '0) && !em_ack_reg;
            end else if (em_mask_reg != '0) begin
                push_item.kind   = gclp_pkg::KIND_WORD;
                push_item.letter = gclp_pkg::slot_letter(em_idx);
                push_item.value  = val_ext[31:0];
                push_item.last   = (em_rest == '0) && !em_ack_reg;
            end else begin
                push_item.kind   = gclp_pkg::KIND_ACK;
                push_item.last   = 1'b1;
            end
            if (push_ready) begin
                if (em_hdr_reg) begin
                    em_hdr_next = 1'b0;
                end else if (em_mask_reg != '0) begin
                    em_mask_next = em_rest;
                end else begin
                    em_ack_next = 1'b0;
                end
                if (push_item.last) begin
                    st_next = ST_IDLE;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg         <= ST_IDLE;
            ph_reg         <= PH_LETTER;
            cmd_letter_reg <= '0;
            cmd_num_reg    <= '0;
            slot_reg       <= '0;
            mant_reg       <= '0;
            fdig_reg       <= '0;
            neg_reg        <= 1'b0;
            infrac_reg     <= 1'b0;
            present_reg    <= '0;
            em_hdr_reg     <= 1'b0;
            em_mask_reg    <= '0;
            em_ack_reg     <= 1'b0;
        end else begin
            st_reg         <= st_next;
            ph_reg         <= ph_next;
            cmd_letter_reg <= cmd_letter_next;
            cmd_num_reg    <= cmd_num_next;
            slot_reg       <= slot_next;
            mant_reg       <= mant_next;
            fdig_reg       <= fdig_next;
            neg_reg        <= neg_next;
            infrac_reg     <= infrac_next;
            present_reg    <= present_next;
            em_hdr_reg     <= em_hdr_next;
            em_mask_reg    <= em_mask_next;
            em_ack_reg     <= em_ack_next;
        end
        byte_reg <= byte_next;
        if (val_we) begin
            slot_val_reg[slot_reg] <= val_wdata;
        end
    end

endmodule

>>> sv/gclp_queue.sv
// ----------------------------------------------------------------------------
// gclp_queue: result item queue between sequencer and output channel
// Small FIFO that lets the sequencer push while the receiver stalls.
// ----------------------------------------------------------------------------
module gclp_queue (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push_valid,
    output logic               push_ready,
    input  gclp_pkg::res_t     push_item,
    output logic               pop_valid,
    input  logic               pop_ready,
    output gclp_pkg::res_t     pop_item
);

    localparam int PW = gclp_pkg::QPTR_W;
    localparam int D  = gclp_pkg::QUEUE_DEPTH;

    gclp_pkg::res_t   mem [D];
    logic [PW-1:0]    wr_reg, wr_next;
    logic [PW-1:0]    rd_reg, rd_next;
    logic [PW:0]      cnt_reg, cnt_next;
    logic             push, pop;

    assign push_ready = (cnt_reg != (PW+1)'(D));
    assign pop_valid  = (cnt_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_item   = mem[rd_reg];

    always_comb begin
        wr_next  = push ? wr_reg + PW'(1) : wr_reg;
        rd_next  = pop ? rd_reg + PW'(1) : rd_reg;
        cnt_next = cnt_reg + (PW+1)'(push) - (PW+1)'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
        if (push) begin
            mem[wr_reg] <= push_item;
        end
    end

endmodule

>>> sv/gcode_line_parser.sv
// ----------------------------------------------------------------------------
// gcode_line_parser: streaming G-code line parser
// Takes ASCII bytes on s_axis and emits command headers, parameter words
// and line acknowledges on m_axis.
// ----------------------------------------------------------------------------
// Usage:
//   s_tdata carries one received byte per item. m_tuser gives the result
//   kind (header, parameter word, line acknowledge), m_tdata the letter,
//   command number and Q(FRAC_BITS) value, m_tlast marks the final result
//   caused by one byte.
//   A byte that only updates parser state leaves s_tready high. A byte that ends
//   a number starts the shift-subtract divider, which for a parameter value
//   continues into FRAC_BITS fraction bits; the held byte is processed after
//   it. A terminator then pushes its results, one per cycle while the queue has
//   space, up to 13, into a four-entry queue before s_tready returns.
//   Reset clears the parser to expect a command letter and empties the queue.
//   When the receiver stalls, results wait in the queue; once it fills, the
//   sequencer holds and s_tready stays low until space frees up.
// ----------------------------------------------------------------------------
module gcode_line_parser #(
    parameter int FRAC_BITS       = 16,
    parameter int MAX_FRAC_DIGITS = 6,
    parameter int VALUE_WIDTH     = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // [7:0] letter, [23:8] command_number, [55:24] value
    output logic [1:0]  m_tuser,   // [1:0] kind
    output logic        m_tlast
);

    logic            push_valid;
    logic            push_ready;
    gclp_pkg::res_t  push_item;
    gclp_pkg::res_t  pop_item;

    gclp_front #(
        .FRAC_BITS       (FRAC_BITS),
        .MAX_FRAC_DIGITS (MAX_FRAC_DIGITS),
        .VALUE_WIDTH     (VALUE_WIDTH)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_byte    (s_tdata),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item)
    );

    gclp_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (m_tvalid),
        .pop_ready  (m_tready),
        .pop_item   (pop_item)
    );

    assign m_tdata = {pop_item.value, pop_item.cnum, pop_item.letter};
    assign m_tuser = pop_item.kind;
    assign m_tlast = pop_item.last;

endmodule
